// ===== src/sisc_pkg.sv =====
// Shared types, codes and default constants for the sorted interval set coalescer.
// Used by sisc_alu, sisc_ctrl and the top level; depends on nothing.
package sisc_pkg;

    // Field widths of the channel payloads
    localparam int KIND_W      = 2;
    localparam int OFFSET_W    = 18;
    localparam int LENGTH_W    = 19;
    localparam int STATUS_W    = 2;
    localparam int HOLE_ST_W   = 18;
    localparam int HOLE_SZ_W   = 19;
    localparam int SEG_CNT_W   = 4;
    localparam int COVERED_W   = 19;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_SEGMENTS = 15;
    localparam int DEF_ZONE_BYTES   = 262144;

    // Most holes reported by one list-holes request
    localparam int HOLE_CAP = 16;
    localparam int HOLE_N_W = $clog2(HOLE_CAP + 1);

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 2'd0,
        KIND_HOLES  = 2'd1,
        KIND_FULL   = 2'd2,
        KIND_CLEAR  = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_OVERFLOW  = 2'd1,
        STATUS_BAD_RANGE = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_WALK,
        ST_INS_END,
        ST_HOLE_WALK,
        ST_HOLE_TAIL,
        ST_HOLE_LAST,
        ST_RESP
    } state_t;

    typedef struct packed {
        kind_t                kind;
        logic [OFFSET_W-1:0]  offset;
        logic [LENGTH_W-1:0]  length;
    } in_item_t;

    typedef struct packed {
        status_t               status;
        logic                  hole_valid;
        logic [HOLE_ST_W-1:0]  hole_start;
        logic [HOLE_SZ_W-1:0]  hole_size;
        logic                  last;
        logic [SEG_CNT_W-1:0]  segment_count;
        logic [COVERED_W-1:0]  covered_bytes;
        logic                  zone_full;
    } out_item_t;

    // Compare results of the shared segment unit
    typedef struct packed {
        logic end_lt_lo;   // segment ends before the new range starts
        logic start_le_hi; // segment starts at or before the new range end
        logic start_gt_c;  // segment starts after the cursor (gap in front)
    } alu_flags_t;

endpackage

// ===== src/sisc_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// No dependencies.
module sisc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Read port; data holds while re is low
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== src/sisc_alu.sv =====
// Shared segment unit: end address, gap to cursor, and merge bounds for one stored segment.
// Depends on sisc_pkg.
module sisc_alu
    import sisc_pkg::*;
#(
    parameter int A_W = 19
) (
    input  logic [A_W-1:0] seg_start,
    input  logic [A_W-1:0] seg_size,
    input  logic [A_W-1:0] cursor,
    input  logic [A_W-1:0] lo,
    input  logic [A_W-1:0] hi,
    output logic [A_W-1:0] seg_end,
    output logic [A_W-1:0] gap,
    output logic [A_W-1:0] lo_min,
    output logic [A_W-1:0] hi_max,
    output alu_flags_t     flags
);

    // End of the segment (exclusive)
    assign seg_end = seg_start + seg_size;

    // Uncovered bytes between cursor and segment start
    assign gap = seg_start - cursor;

    // Compares
    always_comb begin
        flags.end_lt_lo   = (seg_end < lo);
        flags.start_le_hi = (seg_start <= hi);
        flags.start_gt_c  = (seg_start > cursor);
    end

    // Bounds of the range after merging this segment in
    assign lo_min = (seg_start < lo) ? seg_start : lo;
    assign hi_max = (seg_end > hi) ? seg_end : hi;

endmodule

// ===== src/sisc_ctrl.sv =====
// Sequencer for the coalescer: walks the segment list in RAM through the shared unit,
// rebuilds the list into the spare bank on insert, and produces result transactions.
// Depends on sisc_pkg, sisc_ram and sisc_alu.
module sisc_ctrl
    import sisc_pkg::*;
#(
    parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS,
    parameter int ZONE_BYTES   = DEF_ZONE_BYTES
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_item,
    input  logic      out_free,
    output logic      emit_valid,
    output out_item_t emit_item
);

    localparam int A_W   = $clog2(ZONE_BYTES + 1);
    localparam int I_W   = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int C_W   = $clog2(MAX_SEGMENTS + 1);
    localparam int W_W   = $clog2(MAX_SEGMENTS + 2);
    localparam int RA_W  = I_W + 1;
    localparam int CHK_W = (A_W > 20) ? A_W : 20;
    localparam int HS_EXT_W = A_W + HOLE_ST_W;
    localparam int HZ_EXT_W = A_W + HOLE_SZ_W;
    localparam int CV_EXT_W = A_W + COVERED_W;
    localparam int CN_EXT_W = C_W + SEG_CNT_W;
    localparam logic [A_W-1:0]   ZONE_A   = A_W'(ZONE_BYTES);
    localparam logic [CHK_W-1:0] ZONE_CHK = CHK_W'(ZONE_BYTES);
    localparam logic [W_W-1:0]   MAX_W    = W_W'(MAX_SEGMENTS);

    // Control state
    state_t             state_reg, state_next;
    logic               bank_reg, bank_next;
    logic [C_W-1:0]     total_reg, total_next;
    logic [A_W-1:0]     cov_reg, cov_next;
    status_t            status_reg, status_next;
    logic               dv_reg, dv_next;
    logic [C_W-1:0]     rd_idx_reg, rd_idx_next;
    logic               placed_reg, placed_next;
    logic [W_W-1:0]     wcount_reg, wcount_next;
    logic               hp_valid_reg, hp_valid_next;
    logic [HOLE_N_W-1:0] nh_reg, nh_next;

    // Working values
    logic [A_W-1:0]     lo_reg, lo_next;
    logic [A_W-1:0]     hi_reg, hi_next;
    logic [A_W-1:0]     sum_reg, sum_next;
    logic [A_W-1:0]     cursor_reg, cursor_next;
    logic [A_W-1:0]     hp_start_reg, hp_start_next;
    logic [A_W-1:0]     hp_size_reg, hp_size_next;

    // RAM ports
    logic               ram_we, ram_re;
    logic [RA_W-1:0]    ram_waddr, ram_raddr;
    logic [2*A_W-1:0]   ram_wdata, ram_rdata;
    logic [A_W-1:0]     rd_start, rd_size;

    // Shared unit ports
    logic               tail_sel;
    logic [A_W-1:0]     alu_start, alu_size;
    logic [A_W-1:0]     seg_end, gap, lo_min, hi_max;
    alu_flags_t         flags;

    // Misc
    logic [A_W-1:0]     merged_size;
    logic               wr_go;
    logic [A_W-1:0]     wr_start, wr_size;
    logic               consume, issue, new_hole;
    logic [CHK_W-1:0]   end_chk;
    logic [W_W-1:0]     cnt_fin;
    logic [A_W-1:0]     sum_fin;
    logic               emit_hole, emit_last;
    logic [HS_EXT_W-1:0] hs_ext;
    logic [HZ_EXT_W-1:0] hz_ext;
    logic [CV_EXT_W-1:0] cv_ext;
    logic [CN_EXT_W-1:0] cn_ext;

    sisc_ram #(
        .WIDTH (2 * A_W),
        .DEPTH (2 ** RA_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_start = ram_rdata[2*A_W-1:A_W];
    assign rd_size  = ram_rdata[A_W-1:0];

    // The zone end acts as a zero-size entry for the trailing hole
    assign alu_start = tail_sel ? ZONE_A : rd_start;
    assign alu_size  = tail_sel ? '0 : rd_size;

    sisc_alu #(
        .A_W (A_W)
    ) u_alu (
        .seg_start (alu_start),
        .seg_size  (alu_size),
        .cursor    (cursor_reg),
        .lo        (lo_reg),
        .hi        (hi_reg),
        .seg_end   (seg_end),
        .gap       (gap),
        .lo_min    (lo_min),
        .hi_max    (hi_max),
        .flags     (flags)
    );

    assign merged_size = hi_reg - lo_reg;
    assign end_chk     = CHK_W'(in_item.offset) + CHK_W'(in_item.length);
    assign in_ready    = (state_reg == ST_IDLE);

    // Result fields, trimmed to the channel widths
    assign hs_ext = HS_EXT_W'(hp_start_reg);
    assign hz_ext = HZ_EXT_W'(hp_size_reg);
    assign cv_ext = CV_EXT_W'(cov_reg);
    assign cn_ext = CN_EXT_W'(total_reg);

    always_comb begin
        emit_item.status        = emit_hole ? STATUS_OK : status_reg;
        emit_item.hole_valid    = emit_hole;
        emit_item.hole_start    = emit_hole ? hs_ext[HOLE_ST_W-1:0] : '0;
        emit_item.hole_size     = emit_hole ? hz_ext[HOLE_SZ_W-1:0] : '0;
        emit_item.last          = emit_last;
        emit_item.segment_count = cn_ext[SEG_CNT_W-1:0];
        emit_item.covered_bytes = cv_ext[COVERED_W-1:0];
        emit_item.zone_full     = (cov_reg == ZONE_A);
    end

    // Next state and datapath control
    always_comb begin
        state_next    = state_reg;
        bank_next     = bank_reg;
        total_next    = total_reg;
        cov_next      = cov_reg;
        status_next   = status_reg;
        dv_next       = dv_reg;
        rd_idx_next   = rd_idx_reg;
        placed_next   = placed_reg;
        wcount_next   = wcount_reg;
        hp_valid_next = hp_valid_reg;
        nh_next       = nh_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        sum_next      = sum_reg;
        cursor_next   = cursor_reg;
        hp_start_next = hp_start_reg;
        hp_size_next  = hp_size_reg;

        ram_we    = 1'b0;
        ram_waddr = {bank_reg, I_W'(0)};
        ram_wdata = {{A_W{1'b0}}, ZONE_A};
        ram_re    = 1'b0;
        ram_raddr = {bank_reg, rd_idx_reg[I_W-1:0]};

        tail_sel   = 1'b0;
        wr_go      = 1'b0;
        wr_start   = rd_start;
        wr_size    = rd_size;
        consume    = 1'b0;
        issue      = 1'b0;
        new_hole   = flags.start_gt_c && (nh_reg < HOLE_N_W'(HOLE_CAP));
        cnt_fin    = wcount_reg;
        sum_fin    = sum_reg;
        emit_valid = 1'b0;
        emit_hole  = 1'b0;
        emit_last  = 1'b1;

        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    rd_idx_next = '0;
                    dv_next     = 1'b0;
                    status_next = STATUS_OK;
                    case (in_item.kind)
                        KIND_INSERT: begin
                            if (in_item.length == '0 || end_chk > ZONE_CHK) begin
                                status_next = STATUS_BAD_RANGE;
                                state_next  = ST_RESP;
                            end else begin
                                lo_next     = A_W'(in_item.offset);
                                hi_next     = A_W'(end_chk);
                                placed_next = 1'b0;
                                wcount_next = '0;
                                sum_next    = '0;
                                state_next  = ST_INS_WALK;
                            end
                        end
                        KIND_HOLES: begin
                            cursor_next   = '0;
                            nh_next       = '0;
                            hp_valid_next = 1'b0;
                            state_next    = ST_HOLE_WALK;
                        end
                        KIND_FULL: begin
                            // One segment covering the whole zone
                            ram_we     = 1'b1;
                            total_next = C_W'(1);
                            cov_next   = ZONE_A;
                            state_next = ST_RESP;
                        end
                        KIND_CLEAR: begin
                            total_next = '0;
                            cov_next   = '0;
                            state_next = ST_RESP;
                        end
                        default: begin
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end

            ST_INS_WALK: begin
                // Classify the entry on the read port: prefix, merge, or suffix
                if (dv_reg) begin
                    if (!placed_reg && flags.end_lt_lo) begin
                        wr_go   = 1'b1;
                        consume = 1'b1;
                    end else if (!placed_reg && flags.start_le_hi) begin
                        lo_next = lo_min;
                        hi_next = hi_max;
                        consume = 1'b1;
                    end else if (!placed_reg) begin
                        // Merged range goes first; the entry is held and written after it
                        wr_go       = 1'b1;
                        wr_start    = lo_reg;
                        wr_size     = merged_size;
                        placed_next = 1'b1;
                    end else begin
                        wr_go   = 1'b1;
                        consume = 1'b1;
                    end
                end
                issue = (rd_idx_reg < total_reg) && (!dv_reg || consume);
                if (!dv_reg && rd_idx_reg == total_reg) begin
                    state_next = ST_INS_END;
                end
            end

            ST_INS_END: begin
                // Place the merged range if nothing followed it, then commit
                if (!placed_reg) begin
                    wr_go    = 1'b1;
                    wr_start = lo_reg;
                    wr_size  = merged_size;
                    cnt_fin  = wcount_reg + W_W'(1);
                    sum_fin  = sum_reg + merged_size;
                end
                if (cnt_fin > MAX_W) begin
                    status_next = STATUS_OVERFLOW;
                end else begin
                    status_next = STATUS_OK;
                    bank_next   = ~bank_reg;
                    total_next  = C_W'(cnt_fin);
                    cov_next    = sum_fin;
                end
                state_next = ST_RESP;
            end

            ST_HOLE_WALK: begin
                consume = dv_reg && !(new_hole && hp_valid_reg && !out_free);
                if (consume) begin
                    cursor_next = seg_end;
                    if (new_hole) begin
                        emit_valid    = hp_valid_reg;
                        emit_hole     = 1'b1;
                        emit_last     = 1'b0;
                        hp_start_next = cursor_reg;
                        hp_size_next  = gap;
                        hp_valid_next = 1'b1;
                        nh_next       = nh_reg + HOLE_N_W'(1);
                    end
                end
                issue = (rd_idx_reg < total_reg) && (!dv_reg || consume);
                if (!dv_reg && rd_idx_reg == total_reg) begin
                    state_next = ST_HOLE_TAIL;
                end
            end

            ST_HOLE_TAIL: begin
                // Gap between the last segment and the zone end
                tail_sel = 1'b1;
                if (!(new_hole && hp_valid_reg && !out_free)) begin
                    if (new_hole) begin
                        emit_valid    = hp_valid_reg;
                        emit_hole     = 1'b1;
                        emit_last     = 1'b0;
                        hp_start_next = cursor_reg;
                        hp_size_next  = gap;
                        hp_valid_next = 1'b1;
                        nh_next       = nh_reg + HOLE_N_W'(1);
                    end
                    state_next = ST_HOLE_LAST;
                end
            end

            ST_HOLE_LAST: begin
                if (hp_valid_reg) begin
                    emit_hole = 1'b1;
                    if (out_free) begin
                        emit_valid = 1'b1;
                        state_next = ST_IDLE;
                    end
                end else begin
                    state_next = ST_RESP;
                end
            end

            ST_RESP: begin
                if (out_free) begin
                    emit_valid = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // Read stream: one entry in flight, held while not consumed
        if (issue) begin
            ram_re      = 1'b1;
            rd_idx_next = rd_idx_reg + C_W'(1);
        end
        if (state_reg == ST_INS_WALK || state_reg == ST_HOLE_WALK) begin
            dv_next = issue || (dv_reg && !consume);
        end

        // List rebuild writes go to the spare bank
        if (wr_go) begin
            ram_we      = (wcount_reg < MAX_W);
            ram_waddr   = {~bank_reg, wcount_reg[I_W-1:0]};
            ram_wdata   = {wr_start, wr_size};
            wcount_next = wcount_reg + W_W'(1);
            sum_next    = sum_reg + wr_size;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            bank_reg     <= 1'b0;
            total_reg    <= '0;
            cov_reg      <= '0;
            status_reg   <= STATUS_OK;
            dv_reg       <= 1'b0;
            rd_idx_reg   <= '0;
            placed_reg   <= 1'b0;
            wcount_reg   <= '0;
            hp_valid_reg <= 1'b0;
            nh_reg       <= '0;
        end else begin
            state_reg    <= state_next;
            bank_reg     <= bank_next;
            total_reg    <= total_next;
            cov_reg      <= cov_next;
            status_reg   <= status_next;
            dv_reg       <= dv_next;
            rd_idx_reg   <= rd_idx_next;
            placed_reg   <= placed_next;
            wcount_reg   <= wcount_next;
            hp_valid_reg <= hp_valid_next;
            nh_reg       <= nh_next;
        end
    end

    // Working registers
    always_ff @(posedge aclk) begin
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        sum_reg      <= sum_next;
        cursor_reg   <= cursor_next;
        hp_start_reg <= hp_start_next;
        hp_size_reg  <= hp_size_next;
    end

endmodule

// ===== src/sorted_interval_set_coalescer.sv =====
// Sorted interval set coalescer: top level with the channel ports and the result register.
// Depends on sisc_pkg and sisc_ctrl (which holds sisc_ram and sisc_alu).
//
// Usage: a request transaction on s_* (s_valid/s_ready, s_data) carries kind, offset
// and length. Kinds: insert a byte range, list holes, mark the zone full, clear.
// Each request yields result transactions on m_* (m_valid/m_ready, m_data): one
// for insert, mark-full and clear; one per uncovered range (up to HOLE_CAP) for list holes, with
// last set on the final one (a single hole-less result if the zone is covered).
// The segment list lives in a two-bank RAM; an insert reads the current bank one
// segment per cycle (holding one segment while the new range is placed ahead of it)
// and writes the rebuilt list to the other bank, then swaps unless it overflows.
// s_ready is high only while no request is in progress; one request at a time.
// A result waits in the output register while m_ready is low; the list-holes walk
// pauses with a further hole ready until the register frees. Reset (aresetn low,
// synchronous) empties the list and drops any pending result.
module sorted_interval_set_coalescer
    import sisc_pkg::*;
#(
    parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS,
    parameter int ZONE_BYTES   = DEF_ZONE_BYTES
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    logic      out_valid_reg, out_valid_next;
    out_item_t out_data_reg;
    logic      out_free;
    logic      emit_valid;
    out_item_t emit_item;

    sisc_ctrl #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .ZONE_BYTES   (ZONE_BYTES)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .in_item    (s_data),
        .out_free   (out_free),
        .emit_valid (emit_valid),
        .emit_item  (emit_item)
    );

    // Output register: free when empty or being taken this cycle
    assign out_free = !out_valid_reg || m_ready;

    always_comb begin
        out_valid_next = out_valid_reg;
        if (emit_valid) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_valid) begin
            out_data_reg <= emit_item;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule
